// ----- rtl/agpm_pkg.sv -----
// ----------------------------------------------------------------------------
// agpm_pkg: shared types and constants for the audio gain and peak meter
// Word layouts of the sample and result channels, register indices and the
// fixed field widths of the datapath.
// ----------------------------------------------------------------------------
package agpm_pkg;

  // Default number of metered channels.
  localparam int unsigned NumChannelsDef = 6;

  // Number of gain registers; a channel at or above this has no gain.
  localparam int unsigned GainRegs = 6;

  // Field widths.
  localparam int unsigned SampleW   = 16;
  localparam int unsigned ChanW     = 3;
  localparam int unsigned GainW     = 16;
  localparam int unsigned CoeffW    = 16;
  localparam int unsigned MaskW     = 6;
  localparam int unsigned MeterW    = 39;
  localparam int unsigned MaxPowW   = 31;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;

  // Reset values of the configuration registers.
  localparam logic [GainW-1:0]  UnityGain   = 16'd4096;
  localparam logic [MaskW-1:0]  MaskAllOn   = 6'h3F;
  localparam logic [CoeffW-1:0] CoeffNone   = 16'd0;

  // Register indices on the configuration port.
  localparam logic [CfgIdxW-1:0] RegGainCh0     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGainCh5     = 3'd5;
  localparam logic [CfgIdxW-1:0] RegEnableMask  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegDecayCoeff  = 3'd7;

  // Incoming sample word.
  typedef struct packed {
    logic signed [SampleW-1:0] in_sample;
    logic        [ChanW-1:0]   in_channel;
  } in_word_t;

  // Outgoing result word.
  typedef struct packed {
    logic signed [SampleW-1:0] out_sample;
    logic        [ChanW-1:0]   out_channel;
    logic        [MeterW-1:0]  meter_power;
    logic        [MaxPowW-1:0] max_input_power;
  } out_word_t;

endpackage

// ----- rtl/audio_gain_peak_meter.sv -----
// ----------------------------------------------------------------------------
// audio_gain_peak_meter: per-channel gain with peak meter and maximum probe
// Scales interleaved Q1.15 samples by a Q4.12 gain per channel, keeps the
// largest input power and a decaying peak meter of the scaled power.
// ----------------------------------------------------------------------------
// Usage:
// A sample word enters on the in channel when in_valid_i is high and
// in_stall_o is low. The block then works on that word alone and holds
// in_stall_o high until the result has been placed in the output register.
// One 32 x 32 multiplier is shared under a small sequencer: an enabled
// channel takes up to five multiplies plus compare and update steps (PIN,
// VMAG, POW, CMP, then LO, HI and UPD unless the meter rises); a disabled
// or unknown channel goes straight to the final step. A new word is taken
// only once the sequencer is back in idle after the result is registered.
// The result waits in the output register while out_stall_i is high; the
// next word may already be accepted and worked on, and it waits in its
// final step until the register is free.
// Reset clears the meters and maxima, sets every gain to unity, enables
// all channels and sets the decay coefficient to zero. The user must write
// configuration through cfg_we_i, cfg_idx_i and cfg_data_i only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module audio_gain_peak_meter #(
  parameter int unsigned NUM_CHANNELS = agpm_pkg::NumChannelsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // sample channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  agpm_pkg::in_word_t              in_data_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output agpm_pkg::out_word_t             out_data_o,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [agpm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [agpm_pkg::CfgDataW-1:0]   cfg_data_i
);
  import agpm_pkg::*;

  localparam int unsigned ChIdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned MagW   = SampleW;
  localparam int unsigned VmagW  = 31;
  localparam int unsigned PowW   = 38;
  localparam int unsigned MulW   = 32;
  localparam int unsigned LoW    = 20;
  localparam int unsigned HiW    = MeterW - LoW;

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PIN  = 4'd1;
  localparam logic [3:0] S_VMAG = 4'd2;
  localparam logic [3:0] S_POW  = 4'd3;
  localparam logic [3:0] S_CMP  = 4'd4;
  localparam logic [3:0] S_LO   = 4'd5;
  localparam logic [3:0] S_HI   = 4'd6;
  localparam logic [3:0] S_UPD  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]                state_q, state_d;

  // Configuration registers.
  logic [GainW-1:0]          gain_q [GainRegs];
  logic [MaskW-1:0]          mask_q;
  logic [CoeffW-1:0]         coeff_q;

  // Per-channel state.
  logic [MeterW-1:0]         meter_q [NUM_CHANNELS];
  logic [MaxPowW-1:0]        maxp_q  [NUM_CHANNELS];

  // Word under work.
  logic signed [SampleW-1:0] samp_q;
  logic [ChanW-1:0]          ch_q;
  logic [MagW-1:0]           mag_q;
  logic                      ok_q;
  logic                      act_q;

  // Intermediate results.
  logic [MaxPowW-1:0]        pin_q;
  logic [VmagW-1:0]          vmag_q;
  logic [PowW-1:0]           pow_q;
  logic [MeterW-1:0]         diff_q;
  logic [LoW+CoeffW-1:0]     lo_q;
  logic [HiW+CoeffW-1:0]     hi_q;
  logic signed [SampleW-1:0] res_q;

  // Output register.
  logic                      out_valid_q;
  out_word_t                 out_q;

  // Combinational helpers.
  logic                      accept;
  logic                      out_free;
  logic                      in_ok;
  logic                      in_act;
  logic [ChIdxW-1:0]         idx;
  logic [MeterW-1:0]         meter_rd;
  logic [MaxPowW-1:0]        maxp_rd;
  logic [MulW-1:0]           mul_a;
  logic [MulW-1:0]           mul_b;
  logic [2*MulW-1:0]         mul_p;
  logic [MeterW+CoeffW:0]    dec_sum;
  logic [MeterW-1:0]         dec_amt;
  logic signed [32:0]        rnd_sum;
  logic signed [20:0]        rnd_val;
  logic signed [SampleW-1:0] rnd_sat;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign idx      = ch_q[ChIdxW-1:0];
  assign meter_rd = meter_q[idx];
  assign maxp_rd  = maxp_q[idx];

  // A channel is metered only if it has a store, a gain and its enable bit.
  always_comb begin
    in_ok  = (32'(in_data_i.in_channel) < NUM_CHANNELS) &&
             (32'(in_data_i.in_channel) < GainRegs);
    in_act = 1'b0;
    if (in_ok) begin
      in_act = mask_q[in_data_i.in_channel];
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_PIN: begin
        mul_a = MulW'(mag_q);
        mul_b = MulW'(mag_q);
      end
      S_VMAG: begin
        mul_a = MulW'(mag_q);
        mul_b = MulW'(gain_q[ch_q]);
      end
      S_POW: begin
        mul_a = MulW'(vmag_q);
        mul_b = MulW'(vmag_q);
      end
      S_LO: begin
        mul_a = MulW'(diff_q[LoW-1:0]);
        mul_b = MulW'(coeff_q);
      end
      S_HI: begin
        mul_a = MulW'(diff_q[MeterW-1:LoW]);
        mul_b = MulW'(coeff_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Decay amount: the two partial products recombined and scaled by 2^-16.
  assign dec_sum = {1'b0, hi_q, {LoW{1'b0}}} + (MeterW+CoeffW+1)'(lo_q);
  assign dec_amt = dec_sum[MeterW+CoeffW-1:CoeffW];

  // Rounding of the scaled sample to Q1.15, half up, then hard clipping.
  always_comb begin
    if (samp_q[SampleW-1]) begin
      rnd_sum = -$signed({2'b00, vmag_q}) + 33'sd2048;
    end else begin
      rnd_sum = $signed({2'b00, vmag_q}) + 33'sd2048;
    end
    rnd_val = rnd_sum[32:12];
    if (rnd_val > 21'sd32767) begin
      rnd_sat = 16'sh7FFF;
    end else if (rnd_val < -21'sd32768) begin
      rnd_sat = 16'sh8000;
    end else begin
      rnd_sat = rnd_val[SampleW-1:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = in_act ? S_PIN : S_DONE;
        end
      end
      S_PIN:  state_d = S_VMAG;
      S_VMAG: state_d = S_POW;
      S_POW:  state_d = S_CMP;
      S_CMP:  state_d = ({1'b0, pow_q} > meter_rd) ? S_DONE : S_LO;
      S_LO:   state_d = S_HI;
      S_HI:   state_d = S_UPD;
      S_UPD:  state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < GainRegs; k++) begin
        gain_q[k] <= UnityGain;
      end
      mask_q  <= MaskAllOn;
      coeff_q <= CoeffNone;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i) inside
        [RegGainCh0:RegGainCh5]: gain_q[cfg_idx_i] <= cfg_data_i[GainW-1:0];
        RegEnableMask:           mask_q  <= cfg_data_i[MaskW-1:0];
        RegDecayCoeff:           coeff_q <= cfg_data_i[CoeffW-1:0];
        default: ;
      endcase
    end
  end

  // Meter and maximum stores.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        meter_q[k] <= '0;
        maxp_q[k]  <= '0;
      end
    end else begin
      if (state_q == S_POW && pin_q > maxp_rd) begin
        maxp_q[idx] <= pin_q;
      end
      if (state_q == S_CMP && {1'b0, pow_q} > meter_rd) begin
        meter_q[idx] <= {1'b0, pow_q};
      end
      if (state_q == S_UPD) begin
        meter_q[idx] <= meter_rd - dec_amt;
      end
    end
  end

  // Datapath registers of the word under work.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      samp_q <= in_data_i.in_sample;
      ch_q   <= in_data_i.in_channel;
      mag_q  <= in_data_i.in_sample[SampleW-1] ? MagW'(-in_data_i.in_sample)
                                               : MagW'(in_data_i.in_sample);
      ok_q   <= in_ok;
      act_q  <= in_act;
    end
    if (state_q == S_PIN) begin
      pin_q <= mul_p[MaxPowW-1:0];
    end
    if (state_q == S_VMAG) begin
      vmag_q <= mul_p[VmagW-1:0];
    end
    if (state_q == S_POW) begin
      pow_q <= mul_p[PowW+23:24];
    end
    if (state_q == S_CMP) begin
      diff_q <= meter_rd - {1'b0, pow_q};
      res_q  <= rnd_sat;
    end
    if (state_q == S_LO) begin
      lo_q <= mul_p[LoW+CoeffW-1:0];
    end
    if (state_q == S_HI) begin
      hi_q <= mul_p[HiW+CoeffW-1:0];
    end
  end

  // Output register: loaded at the end of a word, cleared when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      out_q.out_sample      <= act_q ? res_q : samp_q;
      out_q.out_channel     <= ch_q;
      out_q.meter_power     <= ok_q ? meter_rd : '0;
      out_q.max_input_power <= ok_q ? maxp_rd : '0;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A result appears only from the final step of a word.
  a_out_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result word registered outside the final step");

  // A free output register takes the result and releases the sequencer.
  a_done_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !out_valid_q) |=> (out_valid_q && state_q == S_IDLE))
    else $error("final step did not hand its result to the output register");

  // The decay never takes the meter below the new scaled power.
  a_decay_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> (dec_amt <= diff_q))
    else $error("meter decay larger than the distance to the new power");

  // The channel of the word under work holds until the word is finished.
  a_chan_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && state_q != S_DONE) |=> $stable(ch_q))
    else $error("channel changed while a word was being processed");

endmodule
